FILE: sv/fpq_pkg.sv
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types and constants of the Q16.16 divider pipeline.
// ----------------------------------------------------------------------------
package fpq_pkg;

  // width of the operand and result words
  localparam int unsigned WORD_W   = 32;
  // quotient bits resolved in one pipeline stage
  localparam int unsigned DIV_STEP = 2;

  // control that travels alongside each word through the pipeline
  typedef struct packed {
    logic valid;
    logic neg;
    logic zdiv;
  } fpq_ctrl_t;

endpackage

FILE: sv/fpq_prep.sv
// ----------------------------------------------------------------------------
// fpq_prep
// Entry stage: takes operand magnitudes, result sign and the zero check.
// ----------------------------------------------------------------------------
module fpq_prep #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned TOT_W     = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [31:0]            dividend_i,
  input  logic signed [31:0]            divisor_i,
  output fpq_pkg::fpq_ctrl_t            ctrl_o,
  output logic [fpq_pkg::WORD_W-1:0]    den_o,
  output logic [TOT_W-1:0]              num_o
);
  import fpq_pkg::*;

  logic [WORD_W-1:0] na, nb;
  fpq_ctrl_t         ctrl_d, ctrl_q;
  logic [WORD_W-1:0] den_q;
  logic [TOT_W-1:0]  num_d, num_q;

  // most negative value maps to 2^31, which fits the unsigned word
  assign na = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
  assign nb = divisor_i[31]  ? (~divisor_i + 32'd1)  : divisor_i;

  always_comb begin
    ctrl_d.valid = valid_i;
    ctrl_d.neg   = dividend_i[31] ^ divisor_i[31];
    ctrl_d.zdiv  = (divisor_i == '0);
    num_d        = TOT_W'(na) << FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= nb;
      num_q <= num_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign den_o  = den_q;
  assign num_o  = num_q;

endmodule

FILE: sv/fpq_div_stage.sv
// ----------------------------------------------------------------------------
// fpq_div_stage
// One restoring division stage: resolves DIV_STEP quotient bits.
// ----------------------------------------------------------------------------
module fpq_div_stage #(
  parameter int unsigned TOT_W = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  fpq_pkg::fpq_ctrl_t            ctrl_i,
  input  logic [fpq_pkg::WORD_W-1:0]    den_i,
  input  logic [fpq_pkg::WORD_W-1:0]    rem_i,
  input  logic [TOT_W-1:0]              num_i,
  output fpq_pkg::fpq_ctrl_t            ctrl_o,
  output logic [fpq_pkg::WORD_W-1:0]    den_o,
  output logic [fpq_pkg::WORD_W-1:0]    rem_o,
  output logic [TOT_W-1:0]              num_o
);
  import fpq_pkg::*;

  fpq_ctrl_t         ctrl_q;
  logic [WORD_W-1:0] den_q, rem_d, rem_q;
  logic [TOT_W-1:0]  num_d, num_q;

  // numerator bits shift out at the top, quotient bits shift in at the bottom
  always_comb begin
    logic [WORD_W:0]   t;
    logic [WORD_W:0]   diff;
    logic              ge;
    rem_d = rem_i;
    num_d = num_i;
    for (int i = 0; i < DIV_STEP; i++) begin
      t     = {rem_d, num_d[TOT_W-1]};
      diff  = t - {1'b0, den_i};
      ge    = (t >= {1'b0, den_i});
      rem_d = ge ? diff[WORD_W-1:0] : t[WORD_W-1:0];
      num_d = {num_d[TOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= den_i;
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign den_o  = den_q;
  assign rem_o  = rem_q;
  assign num_o  = num_q;

endmodule

FILE: sv/fpq_post.sv
// ----------------------------------------------------------------------------
// fpq_post
// Exit stage: overflow check, sign restore and the output register.
// ----------------------------------------------------------------------------
module fpq_post #(
  parameter int unsigned TOT_W = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  fpq_pkg::fpq_ctrl_t   ctrl_i,
  input  logic [TOT_W-1:0]     num_i,
  output logic                 valid_o,
  output logic signed [31:0]   quotient_o,
  output logic                 overflowed_o,
  output logic                 zero_divisor_o
);
  import fpq_pkg::*;

  logic              valid_q;
  logic [WORD_W-1:0] quot_d, quot_q;
  logic              ovf_d, ovf_q, zdiv_q;
  logic              ovf_pos, ovf_neg;

  // positive result tops out at 2^31-1, negative one at 2^31
  assign ovf_pos = |num_i[TOT_W-1:31];
  assign ovf_neg = (|num_i[TOT_W-1:32]) | (num_i[31] & (|num_i[30:0]));

  always_comb begin
    if (ctrl_i.zdiv) begin
      quot_d = '0;
      ovf_d  = 1'b0;
    end else begin
      quot_d = ctrl_i.neg ? (~num_i[WORD_W-1:0] + 32'd1) : num_i[WORD_W-1:0];
      ovf_d  = ctrl_i.neg ? ovf_neg : ovf_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
      ovf_q  <= ovf_d;
      zdiv_q <= ctrl_i.zdiv;
    end
  end

  assign valid_o        = valid_q;
  assign quotient_o     = quot_q;
  assign overflowed_o   = ovf_q;
  assign zero_divisor_o = zdiv_q;

endmodule

FILE: sv/fixed_point_q16_divide.sv
// ----------------------------------------------------------------------------
// fixed_point_q16_divide
// Pipelined signed fixed-point divider, one quotient per operand pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o carries dividend_i and divisor_i,
//   both signed fixed-point words with FRAC_BITS fraction bits. Output channel
//   out_valid_o / out_ready_i carries quotient_o, overflowed_o and
//   zero_divisor_o. A word moves when valid and ready are both high.
//   Throughput is one pair per cycle while the receiver does not stall. The
//   pipeline has one entry stage, NSTAGE = ceil((32 + FRAC_BITS) / 2)
//   restoring division stages resolving two quotient bits each, and one
//   output stage. The chain of compare-subtract steps in a division stage
//   sets the clock.
//   A zero divisor gives quotient 0 with zero_divisor_o set. Overflow wraps
//   and raises overflowed_o.
//   Reset empties the pipeline; no results are pending afterwards.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fixed_point_q16_divide #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] quotient_o,
  output logic               overflowed_o,
  output logic               zero_divisor_o
);
  import fpq_pkg::*;

  localparam int unsigned NSTAGE = (WORD_W + FRAC_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned TOT_W  = NSTAGE * DIV_STEP;

  logic              en;
  fpq_ctrl_t         ctrl_s [NSTAGE+1];
  logic [WORD_W-1:0] den_s  [NSTAGE+1];
  logic [WORD_W-1:0] rem_s  [NSTAGE+1];
  logic [TOT_W-1:0]  num_s  [NSTAGE+1];

  // hold every stage while a result waits at the output
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  fpq_prep #(
    .FRAC_BITS (FRAC_BITS),
    .TOT_W     (TOT_W)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .ctrl_o     (ctrl_s[0]),
    .den_o      (den_s[0]),
    .num_o      (num_s[0])
  );

  // partial remainder starts empty
  assign rem_s[0] = '0;

  for (genvar g = 0; g < NSTAGE; g++) begin : g_div
    fpq_div_stage #(
      .TOT_W (TOT_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl_s[g]),
      .den_i  (den_s[g]),
      .rem_i  (rem_s[g]),
      .num_i  (num_s[g]),
      .ctrl_o (ctrl_s[g+1]),
      .den_o  (den_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .num_o  (num_s[g+1])
    );
  end

  fpq_post #(
    .TOT_W (TOT_W)
  ) u_post (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .ctrl_i         (ctrl_s[NSTAGE]),
    .num_i          (num_s[NSTAGE]),
    .valid_o        (out_valid_o),
    .quotient_o     (quotient_o),
    .overflowed_o   (overflowed_o),
    .zero_divisor_o (zero_divisor_o)
  );

  // a stalled result must block new input
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  // a zero divisor forces a clean zero result
  a_zdiv_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divisor_o |-> quotient_o == '0 && !overflowed_o)
    else $error("zero divisor result not cleared");

  // a word leaving the last division stage reaches the output register
  a_last_stage_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && ctrl_s[NSTAGE].valid |=> out_valid_o)
    else $error("word lost between last stage and output");

endmodule

FILE: tb/tb_fixed_point_q16_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_q16_divide
// Self-checking bench for the pipelined signed Q16.16 divider.
// A queue of operand pairs feeds a falling-edge driver with random gaps; a
// rising-edge monitor predicts each quotient on acceptance and checks every
// returned word, field by field, in order. The receiver stalls at random,
// twice for long enough to back the pipeline up to its input.
// ----------------------------------------------------------------------------
module tb_fixed_point_q16_divide;
  import fpq_pkg::WORD_W;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned RAND_PAIRS  = 500;

  localparam logic signed [WORD_W-1:0] Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic signed [WORD_W-1:0] dividend;
    logic signed [WORD_W-1:0] divisor;
    logic [3:0]               lead_gap;
    logic                     drain_first;
  } operand_pair_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] quotient;
    logic                     overflowed;
    logic                     zero_divisor;
  } quot_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic signed [WORD_W-1:0] dividend_i  = '0;
  logic signed [WORD_W-1:0] divisor_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [WORD_W-1:0] quotient_o;
  logic                     overflowed_o;
  logic                     zero_divisor_o;

  operand_pair_t pending_pairs[$];
  quot_word_t    quot_expected[$];

  int unsigned sent_cnt  = 0;
  int unsigned taken_cnt = 0;
  int unsigned got_cnt   = 0;
  int unsigned mismatches = 0;
  int unsigned ovf_seen  = 0;
  int unsigned zdiv_seen = 0;
  int unsigned idle_cycles = 0;

  fixed_point_q16_divide #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .dividend_i    (dividend_i),
    .divisor_i     (divisor_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .quotient_o    (quotient_o),
    .overflowed_o  (overflowed_o),
    .zero_divisor_o(zero_divisor_o)
  );

  always #4 clk_i = ~clk_i;

  // Magnitudes divided as integers, then FRAC_BITS more bits by restoring
  // long division on the remainder; wrap to 32 bits and negate on sign mismatch.
  function automatic quot_word_t divide_q16(logic signed [WORD_W-1:0] num,
                                            logic signed [WORD_W-1:0] den);
    logic [63:0] num_mag, den_mag, whole, rem, mag;
    logic        neg;
    quot_word_t  res;
    res = '0;
    if (den == 0) begin
      res.zero_divisor = 1'b1;
      return res;
    end
    neg     = num[WORD_W-1] ^ den[WORD_W-1];
    num_mag = num[WORD_W-1] ? 64'h1_0000_0000 - {32'b0, num} : {32'b0, num};
    den_mag = den[WORD_W-1] ? 64'h1_0000_0000 - {32'b0, den} : {32'b0, den};
    whole   = num_mag / den_mag;
    rem     = num_mag % den_mag;
    mag     = whole << FRAC_BITS;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      if (rem >= den_mag) begin
        rem = rem - den_mag;
        mag[FRAC_BITS-1-i] = 1'b1;
      end
    end
    // a negative result may reach -2^31 exactly
    res.overflowed = neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF);
    res.quotient   = neg ? -mag[31:0] : mag[31:0];
    return res;
  endfunction

  function automatic logic signed [WORD_W-1:0] edge_operand();
    case ($urandom_range(0, 6))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return 32'sd1;
      4:       return -32'sd1;
      5:       return Q_ONE;
      default: return -Q_ONE;
    endcase
  endfunction

  task automatic queue_pair(logic signed [WORD_W-1:0] num, logic signed [WORD_W-1:0] den,
                            int unsigned gap, bit drain);
    operand_pair_t p;
    p.dividend    = num;
    p.divisor     = den;
    p.lead_gap    = gap[3:0];
    p.drain_first = drain;
    pending_pairs.push_back(p);
  endtask

  // Sender: hold a word until taken, then wait its gap (and a drain if marked) before offering the next.
  int unsigned gap_cnt = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_cnt    = 0;
    end else if (in_valid_i && taken_cnt != sent_cnt) begin
      in_valid_i <= 1'b1;
    end else if (pending_pairs.size() == 0) begin
      in_valid_i <= 1'b0;
    end else if (gap_cnt < pending_pairs[0].lead_gap) begin
      gap_cnt++;
      in_valid_i <= 1'b0;
    end else if (pending_pairs[0].drain_first && quot_expected.size() != 0) begin
      in_valid_i <= 1'b0;
    end else begin
      operand_pair_t p;
      p = pending_pairs.pop_front();
      dividend_i <= p.dividend;
      divisor_i  <= p.divisor;
      in_valid_i <= 1'b1;
      sent_cnt++;
      gap_cnt = 0;
    end
  end

  // Receiver: random stall after each word, a quiet window, and two long holds.
  int unsigned rx_seen    = 0;
  int unsigned stall_left = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (got_cnt != rx_seen) begin
        rx_seen = got_cnt;
        if (got_cnt == 40 || got_cnt == 320)
          stall_left = LONG_HOLD;
        else if (got_cnt >= 120 && got_cnt < 180)
          stall_left = 0;
        else
          stall_left = $urandom_range(0, 9);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        quot_expected.push_back(divide_q16(dividend_i, divisor_i));
        taken_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        got_cnt++;
        if (quot_expected.size() == 0) begin
          $error("unexpected quotient word %0d with nothing pending", quotient_o);
          mismatches++;
        end else begin
          quot_word_t exp_w;
          exp_w = quot_expected.pop_front();
          ovf_seen  += exp_w.overflowed;
          zdiv_seen += exp_w.zero_divisor;
          if (quotient_o !== exp_w.quotient) begin
            $error("quotient: expected %0d, got %0d", exp_w.quotient, quotient_o);
            mismatches++;
          end
          if (overflowed_o !== exp_w.overflowed) begin
            $error("overflowed: expected %0b, got %0b", exp_w.overflowed, overflowed_o);
            mismatches++;
          end
          if (zero_divisor_o !== exp_w.zero_divisor) begin
            $error("zero_divisor: expected %0b, got %0b", exp_w.zero_divisor,
                   zero_divisor_o);
            mismatches++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic signed [WORD_W-1:0] num, den;
    int unsigned gap;

    // directed corners
    queue_pair(32'sd0, Q_ONE, 0, 0);
    queue_pair(32'sd0, -32'sd1, 0, 0);
    queue_pair(32'sd5, 32'sd0, 0, 0);
    queue_pair(Q_MIN, 32'sd0, 0, 0);
    queue_pair(32'sd0, 32'sd0, 0, 0);
    queue_pair(Q_ONE, Q_ONE, 0, 0);
    queue_pair(Q_MAX, Q_MAX, 0, 0);
    queue_pair(Q_MIN, Q_MIN, 0, 0);
    queue_pair(Q_MAX, Q_MIN, 0, 0);
    queue_pair(Q_MIN, Q_MAX, 0, 0);
    queue_pair(Q_MIN, -32'sd1, 0, 0);
    queue_pair(Q_MIN, Q_ONE, 0, 0);
    queue_pair(Q_MIN, -Q_ONE, 0, 0);
    queue_pair(Q_MAX, 32'sd1, 0, 0);
    queue_pair(Q_MIN, 32'sd1, 0, 0);
    queue_pair(32'sd1, Q_MAX, 0, 0);
    queue_pair(-32'sd1, Q_MIN, 0, 0);
    queue_pair(Q_MAX, Q_ONE, 0, 0);
    queue_pair(32'sh0003_0000, -32'sh0002_0000, 0, 0);
    queue_pair(-32'sd7, 32'sd3, 0, 0);
    queue_pair(Q_ONE, 32'sh0003_0000, 0, 0);
    queue_pair(32'sh0000_FFFF, -32'sd1, 0, 0);
    queue_pair(-Q_ONE, 32'sh0007_0000, 0, 0);

    for (int i = 0; i < RAND_PAIRS; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          num = $urandom;
          den = $urandom;
        end
        8, 9, 10: begin
          num = $urandom;
          den = $signed($urandom) >>> $urandom_range(8, 31);
        end
        11: begin
          num = $urandom;
          den = '0;
        end
        12, 13: begin
          num = edge_operand();
          den = $urandom;
        end
        14, 15: begin
          num = $urandom;
          den = edge_operand();
        end
        default: begin
          num = $signed($urandom) >>> $urandom_range(0, 24);
          den = $signed($urandom) >>> $urandom_range(0, 24);
        end
      endcase
      // back-to-back burst in the middle of the run
      gap = (i >= 180 && i < 240) ? 0 : $urandom_range(0, 9);
      queue_pair(num, den, gap, i == 0 || i == 100 || i == 400);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_pairs.size() != 0 || taken_cnt != sent_cnt) @(posedge clk_i);
    while (quot_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (quot_expected.size() != 0) begin
      $error("%0d quotient words never returned", quot_expected.size());
      mismatches++;
    end
    $display("Divided %0d operand pairs, checked %0d quotients (%0d overflowed,",
             taken_cnt, got_cnt, ovf_seen);
    $display("  %0d by zero), with random gaps, bursts and long output stalls.",
             zdiv_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/fpq_pkg.sv
sv/fpq_prep.sv
sv/fpq_div_stage.sv
sv/fpq_post.sv
sv/fixed_point_q16_divide.sv
tb/tb_fixed_point_q16_divide.sv
